### rtl/gccb_pkg.sv
// Shared types and constants of the grid cell cover binner.
`timescale 1ns / 1ps
package gccb_pkg;

    localparam int MAX_SEGMENTS = 1024;
    localparam int MAX_SPAN     = 8;
    localparam int ID_WIDTH     = 16;

    localparam int COORD_W = 11;
    localparam int CELL_W  = 20;
    localparam int IDP_W   = 16;

    localparam logic [IDP_W-1:0] ID_MASK = (ID_WIDTH >= IDP_W) ? {IDP_W{1'b1}} :
        IDP_W'((33'd1 << ID_WIDTH) - 33'd1);

    localparam logic [1:0] REG_SCALE_X = 2'd0;
    localparam logic [1:0] REG_SCALE_Y = 2'd1;
    localparam logic [1:0] REG_CELLS_X = 2'd2;
    localparam logic [1:0] REG_CELLS_Y = 2'd3;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_PUSH
    } front_state_t;

    typedef struct packed {
        logic [COORD_W-1:0] first;
        logic [COORD_W-1:0] stop;
        logic               cut;
    } axis_t;

    typedef struct packed {
        logic [COORD_W-1:0] x_first;
        logic [COORD_W-1:0] x_stop;
        logic [COORD_W-1:0] y_first;
        logic [COORD_W-1:0] y_stop;
        logic [IDP_W-1:0]   id;
        logic               clip;
    } span_t;

endpackage

### rtl/gccb_front.sv
// Front end: takes a particle and works out its cell span on both axes.
`timescale 1ns / 1ps
module gccb_front
    import gccb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [15:0]        particle_id,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic [30:0]        radius,
    input  logic [31:0]        scale_x,
    input  logic [31:0]        scale_y,
    input  logic [COORD_W-1:0] seg_x,
    input  logic [COORD_W-1:0] seg_y,
    input  logic               q_full,
    output logic               q_push,
    output span_t              q_data
);

    front_state_t       state_reg, state_next;
    logic [1:0]         step_reg, step_next;
    logic [32:0]        sum_reg [4];
    logic [31:0]        prod_reg [4];
    logic [IDP_W-1:0]   id_reg;
    logic               accept;
    logic               mul_en;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        mul_p;
    axis_t              ax_x;
    axis_t              ax_y;
    logic               cover_empty;

    function automatic axis_t clamp_axis(
        input logic [32:0]        lo,
        input logic [32:0]        hi,
        input logic [31:0]        lo_p,
        input logic [31:0]        hi_p,
        input logic [31:0]        scale,
        input logic [COORD_W-1:0] n
    );
        axis_t              res;
        logic [31:0]        lo_cell;
        logic [32:0]        hi_cell;
        logic [COORD_W-1:0] hi_c;
        logic [COORD_W-1:0] lo_c;
        logic [COORD_W-1:0] diff;
        lo_cell = lo[32] ? 32'd0 : lo_p;
        if (hi[32])
        begin
            hi_cell = (scale == 32'd0) ? 33'd1 : 33'd0;
        end
        else
        begin
            hi_cell = {1'b0, hi_p} + 33'd1;
        end
        hi_c = (hi_cell > {{(33-COORD_W){1'b0}}, n}) ? n : hi_cell[COORD_W-1:0];
        lo_c = (lo_cell > {{(32-COORD_W){1'b0}}, hi_c}) ? hi_c : lo_cell[COORD_W-1:0];
        diff = hi_c - lo_c;
        res.first = lo_c;
        if (diff > COORD_W'(MAX_SPAN))
        begin
            res.stop = lo_c + COORD_W'(MAX_SPAN);
            res.cut  = 1'b1;
        end
        else
        begin
            res.stop = hi_c;
            res.cut  = 1'b0;
        end
        return res;
    endfunction

    assign accept = push && !full;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    state_next = F_MUL;
                    step_next  = 2'd0;
                end
            end
            F_MUL:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (cover_empty || !q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        full   = 1'b1;
        mul_en = 1'b0;
        q_push = 1'b0;
        unique case (state_reg)
            F_IDLE:  full   = 1'b0;
            F_MUL:   mul_en = 1'b1;
            F_PUSH:  q_push = !cover_empty && !q_full;
            default: full   = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign mul_a = sum_reg[step_reg][31:0];
    assign mul_b = step_reg[1] ? scale_y : scale_x;
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sum_reg[0] <= {pos_x[31], pos_x} - {2'b00, radius};
            sum_reg[1] <= {pos_x[31], pos_x} + {2'b00, radius};
            sum_reg[2] <= {pos_y[31], pos_y} - {2'b00, radius};
            sum_reg[3] <= {pos_y[31], pos_y} + {2'b00, radius};
            id_reg     <= particle_id & ID_MASK;
        end
        if (mul_en)
        begin
            prod_reg[step_reg] <= mul_p[63:32];
        end
    end

    assign ax_x = clamp_axis(sum_reg[0], sum_reg[1], prod_reg[0], prod_reg[1], scale_x, seg_x);
    assign ax_y = clamp_axis(sum_reg[2], sum_reg[3], prod_reg[2], prod_reg[3], scale_y, seg_y);
    assign cover_empty = (ax_x.first >= ax_x.stop) || (ax_y.first >= ax_y.stop);

    assign q_data.x_first = ax_x.first;
    assign q_data.x_stop  = ax_x.stop;
    assign q_data.y_first = ax_y.first;
    assign q_data.y_stop  = ax_y.stop;
    assign q_data.id      = id_reg;
    assign q_data.clip    = ax_x.cut || ax_y.cut;

endmodule

### rtl/gccb_queue.sv
// Two-entry queue of cell spans between the front end and the enumerator.
`timescale 1ns / 1ps
module gccb_queue
    import gccb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  span_t wr_data,
    output logic  q_full,
    input  logic  rd_en,
    output logic  q_empty,
    output span_t rd_data
);

    span_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_wr;
    logic       do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/gccb_back.sv
// Back end: walks the covered cells of one span and emits one pair per cell.
`timescale 1ns / 1ps
module gccb_back
    import gccb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  span_t              q_data,
    output logic               q_pop,
    input  logic [COORD_W-1:0] seg_x,
    output logic               empty,
    input  logic               pop,
    output logic [CELL_W-1:0]  cell_index,
    output logic [IDP_W-1:0]   owner_id,
    output logic               last,
    output logic               clipped
);

    span_t               span_reg;
    logic                busy_reg;
    logic [COORD_W-1:0]  cur_x_reg;
    logic [COORD_W-1:0]  cur_y_reg;
    logic                out_valid_reg;
    logic [CELL_W-1:0]   cell_reg;
    logic [IDP_W-1:0]    id_reg;
    logic                last_reg;
    logic                clip_reg;
    logic                advance;
    logic                emit;
    logic                y_end;
    logic                x_end;
    logic                load;
    logic [2*COORD_W-1:0] row_base;
    logic [CELL_W-1:0]   cell_next;

    assign advance = !out_valid_reg || pop;
    assign emit    = busy_reg && advance;
    assign y_end   = (cur_y_reg + COORD_W'(1)) == span_reg.y_stop;
    assign x_end   = (cur_x_reg + COORD_W'(1)) == span_reg.x_stop;
    assign load    = !q_empty && (!busy_reg || (emit && x_end && y_end));
    assign q_pop   = load;

    assign row_base  = {{COORD_W{1'b0}}, cur_y_reg} * {{COORD_W{1'b0}}, seg_x};
    assign cell_next = CELL_W'(row_base) + CELL_W'(cur_x_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
            end
            else if (emit && x_end && y_end)
            begin
                busy_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            span_reg  <= q_data;
            cur_x_reg <= q_data.x_first;
            cur_y_reg <= q_data.y_first;
        end
        else if (emit)
        begin
            if (y_end)
            begin
                cur_y_reg <= span_reg.y_first;
                cur_x_reg <= cur_x_reg + COORD_W'(1);
            end
            else
            begin
                cur_y_reg <= cur_y_reg + COORD_W'(1);
            end
        end
        if (emit)
        begin
            cell_reg <= cell_next;
            id_reg   <= span_reg.id;
            last_reg <= x_end && y_end;
            clip_reg <= span_reg.clip;
        end
    end

    assign empty      = !out_valid_reg;
    assign cell_index = cell_reg;
    assign owner_id   = id_reg;
    assign last       = last_reg;
    assign clipped    = clip_reg;

endmodule

### rtl/grid_cell_cover_binner.sv
// Top level of the grid cell cover binner: configuration registers and block wiring.
`timescale 1ns / 1ps
// The block takes one particle at a time (id, Q16.16 position and support radius)
// and emits one (cell_index, owner_id) pair for every grid cell covered by the
// square around it, x outer and y inner, with last set on the final pair and
// clipped set on every pair when a span was cut to eight cells.
// Input side: a transfer happens when push is high and full is low. The front
// end then forms the edges, runs the four products through the single 32 by
// 32 multiplier in turn and clamps the spans and queues them.
// Result side: a pair is on the ports while empty is low and is taken by pop.
// The enumerator emits one pair per cycle through its output register while
// pop keeps taking them; the first pair of a particle passes the span queue
// entry and the enumerator's span register first. A two-entry span queue
// lets the front end work on the next particle while pairs are still drained.
// A particle that covers no cell gives no pair. When pop stays low, the
// enumerator holds, the queue fills and full stays high until room returns.
// Reset clears all control state and sets scale 1.0 and one segment per axis.
// The user writes registers through the APB port only while idle (not enforced).
module grid_cell_cover_binner
    import gccb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               push,
    output logic               full,
    input  logic [15:0]        particle_id,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic [30:0]        radius,
    output logic               empty,
    input  logic               pop,
    output logic [19:0]        cell_index,
    output logic [15:0]        owner_id,
    output logic               last,
    output logic               clipped
);

    logic [31:0]        scale_x_reg;
    logic [31:0]        scale_y_reg;
    logic [COORD_W-1:0] cells_x_reg;
    logic [COORD_W-1:0] cells_y_reg;
    logic [COORD_W-1:0] seg_x;
    logic [COORD_W-1:0] seg_y;
    logic               cfg_wr;
    logic [1:0]         reg_sel;
    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;
    span_t              q_wr_data;
    span_t              q_rd_data;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_x_reg <= 32'h0001_0000;
            scale_y_reg <= 32'h0001_0000;
            cells_x_reg <= COORD_W'(1);
            cells_y_reg <= COORD_W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_SCALE_X: scale_x_reg <= pwdata;
                REG_SCALE_Y: scale_y_reg <= pwdata;
                REG_CELLS_X: cells_x_reg <= pwdata[COORD_W-1:0];
                REG_CELLS_Y: cells_y_reg <= pwdata[COORD_W-1:0];
                default:     scale_x_reg <= scale_x_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_SCALE_X: prdata = scale_x_reg;
            REG_SCALE_Y: prdata = scale_y_reg;
            REG_CELLS_X: prdata = {{(32-COORD_W){1'b0}}, cells_x_reg};
            REG_CELLS_Y: prdata = {{(32-COORD_W){1'b0}}, cells_y_reg};
            default:     prdata = 32'd0;
        endcase
    end

    assign seg_x = ({6'd0, cells_x_reg} > 17'(MAX_SEGMENTS)) ? COORD_W'(MAX_SEGMENTS)
                                                           : cells_x_reg;
    assign seg_y = ({6'd0, cells_y_reg} > 17'(MAX_SEGMENTS)) ? COORD_W'(MAX_SEGMENTS)
                                                           : cells_y_reg;

    gccb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .particle_id (particle_id),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .radius      (radius),
        .scale_x     (scale_x_reg),
        .scale_y     (scale_y_reg),
        .seg_x       (seg_x),
        .seg_y       (seg_y),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_wr_data)
    );

    gccb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .q_empty (q_empty),
        .rd_data (q_rd_data)
    );

    gccb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_rd_data),
        .q_pop      (q_pop),
        .seg_x      (seg_x),
        .empty      (empty),
        .pop        (pop),
        .cell_index (cell_index),
        .owner_id   (owner_id),
        .last       (last),
        .clipped    (clipped)
    );

endmodule
